/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL of the breathing wave block.
// Relies on the including module having clk and rst (synchronous, active high).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define LBW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define LBW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/lbw_pkg.sv */
// Package for the breathing wave block: widths, operation and register codes,
// and the channel scaling function. No dependencies.
package lbw_pkg;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Triangle runs 0..COLOR_MAX; one step every period / (levels * 4) ms
  localparam int unsigned COLOR_LEVELS = 256;
  localparam int unsigned STEP_DIV     = 4 * COLOR_LEVELS;
  localparam int unsigned STEP_SHIFT   = $clog2(STEP_DIV);
  localparam logic [LEVEL_W-1:0] COLOR_MAX = LEVEL_W'(COLOR_LEVELS - 1);

  typedef enum logic [OP_W-1:0] {
    OP_UPDATE = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAVE_PERIOD = 2'd0,
    CFG_BASE_COLOR  = 2'd1
  } cfg_reg_t;

  // ch * lvl / 255, truncated. For a product p up to 255 * 255,
  // p / 255 == (p + (p >> 8) + 1) >> 8 exactly.
  function automatic logic [LEVEL_W-1:0] scale_chan(input logic [7:0] ch,
                                                     input logic [7:0] lvl);
    logic [15:0] prod;
    logic [16:0] acc;
    prod = 16'(ch) * 16'(lvl);
    acc  = 17'(prod) + 17'(prod >> 8) + 17'd1;
    return acc[15:8];
  endfunction

endpackage

/* hdl/lbw_in_if.sv */
// Input channel of the breathing wave block: one operation word per handshake.
// Depends on lbw_pkg.
interface lbw_in_if;
  logic                      valid;
  logic                      ready;
  logic [lbw_pkg::OP_W-1:0]   operation;
  logic [lbw_pkg::TIME_W-1:0] now_ms;

  modport source (output valid, output operation, output now_ms, input ready);
  modport sink   (input valid, input operation, input now_ms, output ready);
endinterface

/* hdl/lbw_out_if.sv */
// Result channel of the breathing wave block: one color word per handshake.
// Depends on lbw_pkg.
interface lbw_out_if;
  logic                        valid;
  logic                        ready;
  logic [lbw_pkg::COLOR_W-1:0] pixel_color;
  logic                        is_running;
  logic [lbw_pkg::LEVEL_W-1:0] brightness;

  modport source (output valid, output pixel_color, output is_running,
                  output brightness, input ready);
  modport sink   (input valid, input pixel_color, input is_running,
                  input brightness, output ready);
endinterface

/* hdl/lbw_cfg_if.sv */
// Configuration write channel of the breathing wave block.
// Depends on lbw_pkg.
interface lbw_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lbw_pkg::CFG_IDX_W-1:0]  index;
  logic [lbw_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/led_breathing_wave.sv */
// Breathing LED wave: triangle brightness level scaling a base color.
// Depends on lbw_pkg, lbw_in_if, lbw_out_if, lbw_cfg_if and assert_macros.svh.
//
//   channel | dir | word
//   --------+-----+------------------------------------------
//   item    | in  | operation, now_ms
//   result  | out | pixel_color, is_running, brightness
//   cfg     | in  | index, data (0 wave_period, 1 base_color)
//
// The input register takes the word, then one pass of step/scale logic fills the
// result register. Throughput is one word per cycle while the result is not
// stalled; the state update and the 8x8 color scaling both fit in the single
// pass after the input register.
// Reset clears the config registers, state (going_up is set) and both pipeline valids; cfg is always ready.
// A stalled result holds; one more word may wait in the input register.
module led_breathing_wave (
  input  logic         clk,
  input  logic         rst,
  lbw_in_if.sink       item,
  lbw_out_if.source    result,
  lbw_cfg_if.sink      cfg
);
  import lbw_pkg::*;

  // Configuration registers
  logic [TIME_W-1:0]  wave_period;
  logic [COLOR_W-1:0] base_color;

  // Effect state
  logic               active;
  logic [TIME_W-1:0]  last_step_time;
  logic [LEVEL_W-1:0] level;
  logic               going_up;

  logic               active_next;
  logic [TIME_W-1:0]  last_step_time_next;
  logic [LEVEL_W-1:0] level_next;
  logic               going_up_next;

  // Input register
  logic               s1_valid;
  logic [OP_W-1:0]    s1_op;
  logic [TIME_W-1:0]  s1_now;
  logic               s1_move;
  logic               s1_fire;

  // Result register
  logic               out_valid;
  logic [COLOR_W-1:0] out_color;
  logic               out_running;
  logic [LEVEL_W-1:0] out_level;

  logic [TIME_W-1:0]  elapsed;
  logic               step_due;
  logic [COLOR_W-1:0] color_next;

  // Handshakes
  assign cfg.ready  = 1'b1;
  assign s1_move    = !out_valid || result.ready;
  assign s1_fire    = s1_valid && s1_move;
  assign item.ready = !s1_valid || s1_move;

  assign result.valid       = out_valid;
  assign result.pixel_color = out_color;
  assign result.is_running  = out_running;
  assign result.brightness  = out_level;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_period <= '0;
      base_color  <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_WAVE_PERIOD: wave_period <= cfg.data;
        CFG_BASE_COLOR:  base_color  <= cfg.data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the incoming word
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_op  <= item.operation;
      s1_now <= item.now_ms;
    end
  end

  // Step the triangle
  assign elapsed  = s1_now - last_step_time;
  assign step_due = elapsed > (wave_period >> STEP_SHIFT);

  always_comb begin
    active_next         = active;
    last_step_time_next = last_step_time;
    level_next          = level;
    going_up_next       = going_up;
    case (s1_op)
      OP_UPDATE: begin
        if (!active) begin
          level_next = '0;
        end else if (step_due) begin
          last_step_time_next = s1_now;
          if (going_up) begin
            if (level >= COLOR_MAX) begin
              level_next    = level - LEVEL_W'(1);
              going_up_next = 1'b0;
            end else begin
              level_next = level + LEVEL_W'(1);
            end
          end else if (level == '0) begin
            level_next    = LEVEL_W'(1);
            going_up_next = 1'b1;
          end else begin
            level_next = level - LEVEL_W'(1);
          end
        end
      end
      OP_START: begin
        active_next         = 1'b1;
        last_step_time_next = s1_now;
        level_next          = '0;
        going_up_next       = 1'b1;
      end
      OP_STOP: begin
        active_next = 1'b0;
      end
      default: ;
    endcase
  end

  // Scale each channel by the new level; black while stopped
  always_comb begin
    if (active_next) begin
      color_next = {scale_chan(base_color[23:16], level_next),
                    scale_chan(base_color[15:8],  level_next),
                    scale_chan(base_color[7:0],   level_next)};
    end else begin
      color_next = '0;
    end
  end

  // Commit state when the word moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      last_step_time <= '0;
      level          <= '0;
      going_up       <= 1'b1;
    end else if (s1_fire) begin
      active         <= active_next;
      last_step_time <= last_step_time_next;
      level          <= level_next;
      going_up       <= going_up_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_color   <= color_next;
      out_running <= active_next;
      out_level   <= level_next;
    end
  end

`include "assert_macros.svh"

  `LBW_ASSERT_NOW(a_full_stall_blocks, s1_valid && out_valid && !result.ready, !item.ready, "input accepted while both stages are full and stalled")
  `LBW_ASSERT_NOW(a_dark_when_stopped, out_valid && !out_running, out_color == '0, "nonzero color while effect stopped")
  `LBW_ASSERT_NEXT(a_start_arms, s1_fire && s1_op == OP_START, active && level == '0 && going_up, "start did not arm the effect")
  `LBW_ASSERT_NEXT(a_stop_clears, s1_fire && s1_op == OP_STOP, !active, "stop left the effect running")

endmodule
